// ===== hdl/periodic_command_scheduler_macros.svh =====
// Assertion macros shared by the periodic command scheduler RTL.
`ifndef PERIODIC_COMMAND_SCHEDULER_MACROS_SVH
`define PERIODIC_COMMAND_SCHEDULER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication check, disabled during reset.
`define PCS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("periodic_command_scheduler: same-cycle check failed");
// Next-cycle implication check, disabled during reset.
`define PCS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("periodic_command_scheduler: next-cycle check failed");
`else
`define PCS_ASSERT_IMP(lbl, ante, cons)
`define PCS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/pcs_pkg.sv =====
// Types and constants of the periodic command scheduler.
package pcs_pkg;

  // Default table depth.
  localparam int TABLE_ENTRIES_DEF = 32;

  // Item kinds.
  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_POST = 2'd1;
  localparam logic [1:0] KIND_RUN  = 2'd2;
  localparam logic [1:0] KIND_RESP = 2'd3;

  // One-hot device states.
  localparam logic [7:0] STATE_INIT   = 8'd1;
  localparam logic [7:0] STATE_START  = 8'd2;
  localparam logic [7:0] STATE_ACTIVE = 8'd4;
  localparam logic [7:0] STATE_ERROR  = 8'd8;

  // Period is kept in milliseconds: 16-bit seconds times 1000 fits in 26 bits.
  localparam int          PMS_W         = 26;
  localparam logic [25:0] MS_PER_SECOND = 26'd1000;
  localparam logic [15:0] ERR_PERIOD_RST = 16'd5;

  // One table entry as stored in the command memory.
  typedef struct packed {
    logic [7:0]       code;
    logic [7:0]       mask;
    logic [7:0]       next;
    logic [PMS_W-1:0] period_ms;
    logic             has_flag;
    logic             pending;
    logic [31:0]      start_time;
  } entry_t;

endpackage

// ===== hdl/periodic_command_scheduler.sv =====
// Periodic command scheduler: command table in one memory, scanned per item.
//
// Usage: an item is taken on a clock edge with start high and busy low; its single
// result appears on the out_ ports for one cycle with out_strobe high, and the
// receiver cannot stall it, so it must take every beat. A load item writes its entry
// in the load state and then gives its result. A post item, a run item with the
// link idle and a successful response walk the table one entry per cycle through
// the command memory (one read port, one write port, registered read), stopping at
// the first empty entry or the end of the table; a post item stops at its match.
// A run item with the link busy and a failed response give their result on the
// next cycle. The next item may be started in the cycle that shows the result.
// The configuration register may be written whenever busy is low.
`include "periodic_command_scheduler_macros.svh"

module periodic_command_scheduler #(
  parameter int TABLE_ENTRIES = pcs_pkg::TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Command channel.
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_req_code,
  input  logic        in_success,
  input  logic        in_link_busy,
  input  logic [31:0] in_now_ms,
  input  logic [4:0]  in_entry_index,
  input  logic [7:0]  in_entry_mask,
  input  logic [7:0]  in_entry_next,
  input  logic [15:0] in_entry_period,
  input  logic        in_entry_has_flag,
  input  logic        in_entry_initial,
  // Result channel.
  output logic        out_strobe,
  output logic        out_send_valid,
  output logic [7:0]  out_send_code,
  output logic [7:0]  out_device_state,
  output logic        out_comm_error,
  // Configuration channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_error_period_seconds
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  logic [1:0] state_r, state_nxt;

  // Latched item.
  logic [1:0]  kind_r;
  logic [7:0]  req_code_r;
  logic        success_r;
  logic        link_busy_r;
  logic [31:0] now_r;
  logic [4:0]  idx_r;
  logic [7:0]  mask_r;
  logic [7:0]  next_r;
  logic [15:0] period_r;
  logic        has_flag_r;
  logic        initial_r;

  // Device state, error flag and configuration.
  logic [7:0]  cs_r, cs_nxt;
  logic        err_r, err_nxt;
  logic [15:0] err_period_r;

  // Scan control.
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             rdv_r, rdv_nxt;
  logic             found_r, found_nxt;
  logic [7:0]       code_r, code_nxt;

  // Command memory and its valid bits.
  pcs_pkg::entry_t        mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] vld_r;
  pcs_pkg::entry_t        mem_q_r;
  logic                   vld_q_r;
  logic [IDX_W-1:0]       q_idx_r;
  logic                   rd_en;
  logic [IDX_W-1:0]       rd_addr;
  logic                   mem_we;
  logic [IDX_W-1:0]       mem_waddr;
  pcs_pkg::entry_t        mem_wdata;

  // Result registers.
  logic       out_strobe_r, out_strobe_nxt;
  logic       out_send_valid_r, out_send_valid_nxt;
  logic [7:0] out_send_code_r, out_send_code_nxt;
  logic [7:0] out_device_state_r, out_device_state_nxt;
  logic       out_comm_error_r, out_comm_error_nxt;

  // Per-entry evaluation.
  pcs_pkg::entry_t ent;
  pcs_pkg::entry_t ld_ent;
  logic            accept;
  logic            fin;
  logic            state_known;
  logic [31:0]     elapsed;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);

  assign out_strobe       = out_strobe_r;
  assign out_send_valid   = out_send_valid_r;
  assign out_send_code    = out_send_code_r;
  assign out_device_state = out_device_state_r;
  assign out_comm_error   = out_comm_error_r;

  assign state_known = (cs_r == pcs_pkg::STATE_INIT) || (cs_r == pcs_pkg::STATE_START) ||
                       (cs_r == pcs_pkg::STATE_ACTIVE) || (cs_r == pcs_pkg::STATE_ERROR);

  // Entry data of the last read; never-written slots read as empty.
  assign ent     = vld_q_r ? mem_q_r : '0;
  assign elapsed = now_r - ent.start_time;
  assign rd_addr = cnt_r[IDX_W-1:0];

  // Entry built by a load item; init-state commands also run in error state.
  always_comb begin
    ld_ent            = '0;
    ld_ent.code       = req_code_r;
    ld_ent.next       = next_r;
    ld_ent.has_flag   = has_flag_r;
    ld_ent.pending    = has_flag_r && initial_r;
    ld_ent.start_time = '0;
    if ((mask_r & pcs_pkg::STATE_INIT) != 8'd0) begin
      ld_ent.mask      = mask_r | pcs_pkg::STATE_ERROR;
      ld_ent.period_ms = pcs_pkg::PMS_W'(err_period_r) * pcs_pkg::MS_PER_SECOND;
    end else begin
      ld_ent.mask      = mask_r;
      ld_ent.period_ms = pcs_pkg::PMS_W'(period_r) * pcs_pkg::MS_PER_SECOND;
    end
  end

  // Sequencer: accept, load write, or read-modify-write scan of the table.
  always_comb begin
    state_nxt            = state_r;
    cs_nxt               = cs_r;
    err_nxt              = err_r;
    cnt_nxt              = cnt_r;
    rdv_nxt              = 1'b0;
    found_nxt            = found_r;
    code_nxt             = code_r;
    rd_en                = 1'b0;
    mem_we               = 1'b0;
    mem_waddr            = q_idx_r;
    mem_wdata            = ent;
    fin                  = 1'b0;
    out_strobe_nxt       = 1'b0;
    out_send_valid_nxt   = out_send_valid_r;
    out_send_code_nxt    = out_send_code_r;
    out_device_state_nxt = out_device_state_r;
    out_comm_error_nxt   = out_comm_error_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cnt_nxt   = '0;
          found_nxt = 1'b0;
          code_nxt  = 8'd0;
          if (in_kind == pcs_pkg::KIND_RESP) begin
            err_nxt = !in_success;
          end
          if (in_kind == pcs_pkg::KIND_LOAD) begin
            state_nxt = ST_LOAD;
          end else if ((in_kind == pcs_pkg::KIND_RUN && in_link_busy) ||
                       (in_kind == pcs_pkg::KIND_RESP && !in_success)) begin
            // Nothing to scan: report right away.
            out_strobe_nxt       = 1'b1;
            out_send_valid_nxt   = 1'b0;
            out_send_code_nxt    = 8'd0;
            out_device_state_nxt = cs_r;
            out_comm_error_nxt   = err_nxt;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_LOAD: begin
        // Slots beyond the table are ignored.
        if (32'(idx_r) < 32'(TABLE_ENTRIES)) begin
          mem_we    = 1'b1;
          mem_waddr = IDX_W'(idx_r);
          mem_wdata = ld_ent;
        end
        fin = 1'b1;
      end
      ST_SCAN: begin
        // Evaluate the entry read in the previous cycle.
        if (rdv_r) begin
          if (ent.code == 8'd0) begin
            fin = 1'b1;
          end else begin
            unique case (kind_r)
              pcs_pkg::KIND_POST: begin
                if (ent.code == req_code_r) begin
                  fin = 1'b1;
                  if (ent.has_flag) begin
                    mem_we            = 1'b1;
                    mem_wdata.pending = 1'b1;
                  end
                end
              end
              pcs_pkg::KIND_RUN: begin
                // Issue uses the pending bit before this entry's re-arm.
                if (state_known && !found_r && ((cs_r & ent.mask) != 8'd0) &&
                    ent.has_flag && ent.pending) begin
                  found_nxt = 1'b1;
                  code_nxt  = ent.code;
                end
                if (((cs_r & ent.mask) != 8'd0) && (ent.period_ms != '0) &&
                    ent.has_flag && (elapsed >= 32'(ent.period_ms))) begin
                  mem_we               = 1'b1;
                  mem_wdata.pending    = 1'b1;
                  mem_wdata.start_time = now_r;
                end
              end
              pcs_pkg::KIND_RESP: begin
                if ((ent.code == req_code_r) && ent.has_flag && ent.pending) begin
                  mem_we            = 1'b1;
                  mem_wdata.pending = 1'b0;
                  if (ent.next != 8'd0) begin
                    cs_nxt = ent.next;
                  end
                  if (ent.period_ms != '0) begin
                    mem_wdata.start_time = now_r;
                  end
                end
              end
              default: begin
                // Load items never scan.
              end
            endcase
          end
          if (q_idx_r == IDX_W'(TABLE_ENTRIES - 1)) begin
            fin = 1'b1;
          end
        end
        // Read ahead at the next entry.
        if (!fin && (cnt_r < CNT_W'(TABLE_ENTRIES))) begin
          rd_en   = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          rdv_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Finishing a load or a scan publishes the result.
    if (fin) begin
      state_nxt            = ST_IDLE;
      rdv_nxt              = 1'b0;
      out_strobe_nxt       = 1'b1;
      out_send_valid_nxt   = found_nxt;
      out_send_code_nxt    = code_nxt;
      out_device_state_nxt = cs_nxt;
      out_comm_error_nxt   = err_nxt;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r            <= ST_IDLE;
      cs_r               <= pcs_pkg::STATE_INIT;
      err_r              <= 1'b0;
      err_period_r       <= pcs_pkg::ERR_PERIOD_RST;
      cnt_r              <= '0;
      rdv_r              <= 1'b0;
      found_r            <= 1'b0;
      code_r             <= 8'd0;
      vld_r              <= '0;
      out_strobe_r       <= 1'b0;
      out_send_valid_r   <= 1'b0;
      out_send_code_r    <= 8'd0;
      out_device_state_r <= pcs_pkg::STATE_INIT;
      out_comm_error_r   <= 1'b0;
    end else begin
      state_r            <= state_nxt;
      cs_r               <= cs_nxt;
      err_r              <= err_nxt;
      cnt_r              <= cnt_nxt;
      rdv_r              <= rdv_nxt;
      found_r            <= found_nxt;
      code_r             <= code_nxt;
      out_strobe_r       <= out_strobe_nxt;
      out_send_valid_r   <= out_send_valid_nxt;
      out_send_code_r    <= out_send_code_nxt;
      out_device_state_r <= out_device_state_nxt;
      out_comm_error_r   <= out_comm_error_nxt;
      if (cfg_valid && cfg_ready) begin
        err_period_r <= cfg_error_period_seconds;
      end
      if (mem_we) begin
        vld_r[mem_waddr] <= 1'b1;
      end
    end
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r      <= in_kind;
      req_code_r  <= in_req_code;
      success_r   <= in_success;
      link_busy_r <= in_link_busy;
      now_r       <= in_now_ms;
      idx_r       <= in_entry_index;
      mask_r      <= in_entry_mask;
      next_r      <= in_entry_next;
      period_r    <= in_entry_period;
      has_flag_r  <= in_entry_has_flag;
      initial_r   <= in_entry_initial;
    end
  end

  // Command memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
      vld_q_r <= vld_r[rd_addr];
      q_idx_r <= rd_addr;
    end
  end

  // A command is only issued by a run item that found the link idle.
  `PCS_ASSERT_IMP(a_send_only_on_run, out_strobe_r && out_send_valid_r, (kind_r == pcs_pkg::KIND_RUN) && !link_busy_r)
  // An issued command always carries a nonzero code.
  `PCS_ASSERT_IMP(a_send_code_nonzero, out_strobe_r && out_send_valid_r, out_send_code_r != 8'd0)
  // Read data is only evaluated while a scan is running.
  `PCS_ASSERT_IMP(a_read_in_scan, rdv_r, state_r == ST_SCAN)
  // A failed response reports the error flag on the following cycle.
  `PCS_ASSERT_NXT(a_fail_reports, accept && (in_kind == pcs_pkg::KIND_RESP) && !in_success, out_strobe_r && out_comm_error_r && !success_r)

endmodule

// ===== tb/periodic_command_scheduler_tb.sv =====
// Self-checking testbench for the periodic command scheduler, with directed and random phases.
module periodic_command_scheduler_tb;

  localparam int TBL = pcs_pkg::TABLE_ENTRIES_DEF;

  // One command beat as driven on the in_ ports.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  req_code;
    logic        success;
    logic        link_busy;
    logic [31:0] now_ms;
    logic [4:0]  index;
    logic [7:0]  emask;
    logic [7:0]  enext;
    logic [15:0] eperiod;
    logic        has_flag;
    logic        init_pend;
  } sched_cmd_t;

  // One result beat as seen on the out_ ports.
  typedef struct packed {
    logic       send_valid;
    logic [7:0] send_code;
    logic [7:0] dev_state;
    logic       comm_err;
  } sched_report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_kind = '0;
  logic [7:0]  in_req_code = '0;
  logic        in_success = 1'b0;
  logic        in_link_busy = 1'b0;
  logic [31:0] in_now_ms = '0;
  logic [4:0]  in_entry_index = '0;
  logic [7:0]  in_entry_mask = '0;
  logic [7:0]  in_entry_next = '0;
  logic [15:0] in_entry_period = '0;
  logic        in_entry_has_flag = 1'b0;
  logic        in_entry_initial = 1'b0;
  logic        out_strobe;
  logic        out_send_valid;
  logic [7:0]  out_send_code;
  logic [7:0]  out_device_state;
  logic        out_comm_error;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_error_period_seconds = '0;

  periodic_command_scheduler dut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .start                    (start),
    .busy                     (busy),
    .in_kind                  (in_kind),
    .in_req_code              (in_req_code),
    .in_success               (in_success),
    .in_link_busy             (in_link_busy),
    .in_now_ms                (in_now_ms),
    .in_entry_index           (in_entry_index),
    .in_entry_mask            (in_entry_mask),
    .in_entry_next            (in_entry_next),
    .in_entry_period          (in_entry_period),
    .in_entry_has_flag        (in_entry_has_flag),
    .in_entry_initial         (in_entry_initial),
    .out_strobe               (out_strobe),
    .out_send_valid           (out_send_valid),
    .out_send_code            (out_send_code),
    .out_device_state         (out_device_state),
    .out_comm_error           (out_comm_error),
    .cfg_valid                (cfg_valid),
    .cfg_ready                (cfg_ready),
    .cfg_error_period_seconds (cfg_error_period_seconds)
  );

  // Shadow copy of the command table, device state and period register.
  logic [7:0]  t_code   [TBL];
  logic [7:0]  t_mask   [TBL];
  logic [7:0]  t_next   [TBL];
  logic [15:0] t_period [TBL];
  logic        t_flag   [TBL];
  logic        t_pend   [TBL];
  logic [31:0] t_start  [TBL];
  logic [7:0]  cur_state;
  logic        err_flag;
  logic [15:0] err_period;

  sched_report_t report_q[$];
  int          errors = 0;
  int          kind_count[4] = '{0, 0, 0, 0};
  int          sends_seen = 0;
  int          cfg_writes = 0;
  bit          no_gaps = 1'b0;
  int          live_depth = 1;
  logic [31:0] clock_ms = '0;

  // Clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Advance the shadow scheduler by one command and return the result it should produce.
  task automatic schedule_step(input sched_cmd_t c, output sched_report_t r);
    int          i;
    logic [7:0]  m;
    logic [15:0] p;
    logic [31:0] limit;
    logic        known;
    begin
      r = '0;
      case (c.kind)
        pcs_pkg::KIND_LOAD: begin
          m = c.emask;
          p = c.eperiod;
          // Init-state commands are also allowed in the error state at the error period.
          if ((m & pcs_pkg::STATE_INIT) != 8'd0) begin
            m = m | pcs_pkg::STATE_ERROR;
            p = err_period;
          end
          t_code[c.index]   = c.req_code;
          t_mask[c.index]   = m;
          t_next[c.index]   = c.enext;
          t_period[c.index] = p;
          t_flag[c.index]   = c.has_flag;
          t_pend[c.index]   = c.has_flag & c.init_pend;
          t_start[c.index]  = '0;
        end
        pcs_pkg::KIND_POST: begin
          for (i = 0; i < TBL && t_code[i] != 8'd0; i++) begin
            if (t_code[i] == c.req_code) begin
              if (t_flag[i]) t_pend[i] = 1'b1;
              break;
            end
          end
        end
        pcs_pkg::KIND_RUN: begin
          if (!c.link_busy) begin
            known = (cur_state == pcs_pkg::STATE_INIT) ||
                    (cur_state == pcs_pkg::STATE_START) ||
                    (cur_state == pcs_pkg::STATE_ACTIVE) ||
                    (cur_state == pcs_pkg::STATE_ERROR);
            // Issue the first pending command that the state allows.
            if (known) begin
              for (i = 0; i < TBL && t_code[i] != 8'd0; i++) begin
                if ((cur_state & t_mask[i]) != 8'd0 && t_flag[i] && t_pend[i]) begin
                  r.send_valid = 1'b1;
                  r.send_code  = t_code[i];
                  break;
                end
              end
            end
            // Re-arm periodic commands whose period has run out.
            for (i = 0; i < TBL && t_code[i] != 8'd0; i++) begin
              limit = {16'd0, t_period[i]} * 32'd1000;
              if ((cur_state & t_mask[i]) != 8'd0 && t_period[i] != 16'd0 && t_flag[i] &&
                  (c.now_ms - t_start[i]) >= limit) begin
                t_pend[i]  = 1'b1;
                t_start[i] = c.now_ms;
              end
            end
          end
        end
        default: begin
          err_flag = !c.success;
          if (c.success) begin
            for (i = 0; i < TBL && t_code[i] != 8'd0; i++) begin
              if (t_code[i] == c.req_code && t_flag[i] && t_pend[i]) begin
                t_pend[i] = 1'b0;
                if (t_next[i] != 8'd0) cur_state = t_next[i];
                if (t_period[i] != 16'd0) t_start[i] = c.now_ms;
              end
            end
          end
        end
      endcase
      r.dev_state = cur_state;
      r.comm_err  = err_flag;
    end
  endtask

  // Mostly short sender gaps, a few long ones.
  function automatic int pick_gap();
    int roll;
    begin
      roll = $urandom_range(0, 99);
      if (no_gaps || roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
    end
  endfunction

  // Drive one command beat, wait for it to be taken, then record its expected result.
  task automatic send_item(input sched_cmd_t c);
    sched_report_t r;
    int            gap;
    begin
      start             <= 1'b1;
      in_kind           <= c.kind;
      in_req_code       <= c.req_code;
      in_success        <= c.success;
      in_link_busy      <= c.link_busy;
      in_now_ms         <= c.now_ms;
      in_entry_index    <= c.index;
      in_entry_mask     <= c.emask;
      in_entry_next     <= c.enext;
      in_entry_period   <= c.eperiod;
      in_entry_has_flag <= c.has_flag;
      in_entry_initial  <= c.init_pend;
      @(posedge clk);
      while (busy) @(posedge clk);
      schedule_step(c, r);
      report_q.push_back(r);
      kind_count[c.kind]++;
      gap = pick_gap();
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Hold the sender until every expected result has come back.
  task automatic drain_results();
    begin
      start <= 1'b0;
      while (report_q.size() != 0) @(posedge clk);
      repeat (4) @(posedge clk);
    end
  endtask

  // Write the error period register; only called with the block idle.
  task automatic write_period(input logic [15:0] value);
    begin
      cfg_valid                <= 1'b1;
      cfg_error_period_seconds <= value;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      err_period = value;
      cfg_writes++;
      cfg_valid <= 1'b0;
    end
  endtask

  function automatic sched_cmd_t load_cmd(input logic [4:0] idx, input logic [7:0] code,
                                          input logic [7:0] m, input logic [7:0] nxt,
                                          input logic [15:0] p, input logic flag,
                                          input logic init_pend);
    sched_cmd_t c;
    begin
      c           = '0;
      c.kind      = pcs_pkg::KIND_LOAD;
      c.index     = idx;
      c.req_code  = code;
      c.emask     = m;
      c.enext     = nxt;
      c.eperiod   = p;
      c.has_flag  = flag;
      c.init_pend = init_pend;
      return c;
    end
  endfunction

  function automatic sched_cmd_t op_cmd(input logic [1:0] kind, input logic [7:0] code,
                                        input logic ok, input logic link_busy,
                                        input logic [31:0] now);
    sched_cmd_t c;
    begin
      c           = '0;
      c.kind      = kind;
      c.req_code  = code;
      c.success   = ok;
      c.link_busy = link_busy;
      c.now_ms    = now;
      return c;
    end
  endfunction

  // A code from the live part of the table, so posts and responses usually match.
  function automatic logic [7:0] pick_code();
    logic [7:0] code;
    begin
      code = t_code[$urandom_range(0, live_depth - 1)];
      if (code == 8'd0 || $urandom_range(0, 99) < 15) code = 8'($urandom_range(0, 255));
      return code;
    end
  endfunction

  // A random but mostly well-formed table entry for the given slot.
  function automatic sched_cmd_t random_load(input logic [4:0] idx, input logic [7:0] code);
    sched_cmd_t  c;
    int          roll;
    logic [95:0] raw;
    begin
      raw        = {$urandom, $urandom, $urandom};
      c          = raw[$bits(sched_cmd_t)-1:0];
      c.kind     = pcs_pkg::KIND_LOAD;
      c.index    = idx;
      c.req_code = code;
      if ($urandom_range(0, 99) < 70) c.emask = 8'($urandom_range(1, 15));
      roll = $urandom_range(0, 99);
      if (roll < 25) c.enext = 8'd0;
      else if (roll < 85) c.enext = 8'd1 << $urandom_range(0, 3);
      if ($urandom_range(0, 99) < 70) c.eperiod = 16'($urandom_range(0, 6));
      c.has_flag = ($urandom_range(0, 99) < 85);
      return c;
    end
  endfunction

  // One random command over the live table, with a running millisecond clock.
  function automatic sched_cmd_t random_cmd();
    sched_cmd_t  c;
    int          roll;
    logic [95:0] raw;
    begin
      clock_ms = clock_ms + $urandom_range(0, 2500);
      if ($urandom_range(0, 99) < 3) clock_ms = $urandom;
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        c = random_load(5'($urandom_range(0, live_depth > 31 ? 31 : live_depth)),
                        ($urandom_range(0, 99) < 8) ? 8'd0 : pick_code());
      end else begin
        raw        = {$urandom, $urandom, $urandom};
        c          = raw[$bits(sched_cmd_t)-1:0];
        c.req_code = pick_code();
        if (roll < 35) c.kind = pcs_pkg::KIND_POST;
        else if (roll < 70) begin
          c.kind      = pcs_pkg::KIND_RUN;
          c.link_busy = ($urandom_range(0, 99) < 15);
        end else begin
          c.kind    = pcs_pkg::KIND_RESP;
          c.success = ($urandom_range(0, 99) < 80);
        end
      end
      c.now_ms = clock_ms;
      return c;
    end
  endfunction

  // Compare one field of a result beat and report a mismatch.
  task automatic check_field(input string name, input logic [7:0] expv, input logic [7:0] actv);
    begin
      if (expv !== actv) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, expv, actv);
      end
    end
  endtask

  // Check every result beat against the oldest expectation.
  always @(posedge clk) begin : check_beat
    sched_report_t exp_r;
    if (rst_n && out_strobe) begin
      if (out_send_valid) sends_seen++;
      if (report_q.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, got send %0b code %0h state %0h err %0b",
                 $time, out_send_valid, out_send_code, out_device_state, out_comm_error);
      end else begin
        exp_r = report_q.pop_front();
        check_field("send_valid", {7'd0, exp_r.send_valid}, {7'd0, out_send_valid});
        check_field("send_code", exp_r.send_code, out_send_code);
        check_field("device_state", exp_r.dev_state, out_device_state);
        check_field("comm_error", {7'd0, exp_r.comm_err}, {7'd0, out_comm_error});
      end
    end
  end

  // Scans over an empty table and error flag updates right after reset.
  task automatic test_empty_table();
    begin
      send_item(op_cmd(pcs_pkg::KIND_RUN, 8'd0, 1'b0, 1'b0, 32'd0));
      send_item(op_cmd(pcs_pkg::KIND_RESP, 8'd0, 1'b0, 1'b0, 32'd0));
      send_item(op_cmd(pcs_pkg::KIND_RESP, 8'hFF, 1'b1, 1'b0, 32'd0));
    end
  endtask

  // Loading, posting, issuing, link busy, responses and a timer re-arm.
  task automatic test_load_and_issue();
    begin
      send_item(load_cmd(5'd0, 8'hFF, pcs_pkg::STATE_INIT, pcs_pkg::STATE_START, 16'hFFFF,
                         1'b1, 1'b1));
      send_item(load_cmd(5'd1, 8'h11, pcs_pkg::STATE_START, pcs_pkg::STATE_ACTIVE, 16'd1,
                         1'b1, 1'b0));
      send_item(load_cmd(5'd2, 8'h22, 8'hFF, 8'd0, 16'd0, 1'b0, 1'b1));
      // Slot 31 sits beyond the empty slot 3, so scans never see it.
      send_item(load_cmd(5'd31, 8'h80, pcs_pkg::STATE_ACTIVE, pcs_pkg::STATE_ERROR, 16'hFFFF,
                         1'b1, 1'b1));
      send_item(op_cmd(pcs_pkg::KIND_RUN, 8'd0, 1'b0, 1'b1, 32'd0));
      send_item(op_cmd(pcs_pkg::KIND_RUN, 8'd0, 1'b0, 1'b0, 32'd0));
      // A matching entry without a pending flag stays as it is.
      send_item(op_cmd(pcs_pkg::KIND_POST, 8'h22, 1'b0, 1'b0, 32'd0));
      send_item(op_cmd(pcs_pkg::KIND_POST, 8'h11, 1'b0, 1'b0, 32'd0));
      send_item(op_cmd(pcs_pkg::KIND_RESP, 8'hFF, 1'b1, 1'b0, 32'd100));
      send_item(op_cmd(pcs_pkg::KIND_RUN, 8'd0, 1'b0, 1'b0, 32'd1100));
      send_item(op_cmd(pcs_pkg::KIND_RESP, 8'h11, 1'b0, 1'b0, 32'd1500));
      send_item(op_cmd(pcs_pkg::KIND_RESP, 8'h11, 1'b1, 1'b0, 32'd2000));
    end
  endtask

  // Entering an unknown state, scanning in it, and recovering to init with timer wrap.
  task automatic test_unknown_state();
    begin
      send_item(load_cmd(5'd3, 8'h33, pcs_pkg::STATE_ACTIVE, 8'h80, 16'd0, 1'b1, 1'b1));
      send_item(load_cmd(5'd4, 8'h44, 8'h80, pcs_pkg::STATE_INIT, 16'd2, 1'b1, 1'b1));
      send_item(op_cmd(pcs_pkg::KIND_RESP, 8'h33, 1'b1, 1'b0, 32'd2500));
      send_item(op_cmd(pcs_pkg::KIND_RUN, 8'd0, 1'b0, 1'b0, 32'hFFFF_FFFF));
      send_item(op_cmd(pcs_pkg::KIND_RESP, 8'h44, 1'b1, 1'b0, 32'd5));
      send_item(op_cmd(pcs_pkg::KIND_RUN, 8'd0, 1'b0, 1'b0, 32'h0000_1000));
      send_item(op_cmd(pcs_pkg::KIND_RUN, 8'd0, 1'b0, 1'b0, 32'h0001_0000));
      send_item(op_cmd(pcs_pkg::KIND_RUN, 8'd0, 1'b0, 1'b0, 32'h0001_0001));
      drain_results();
    end
  endtask

  // One random phase: set the error period, rebuild the table, then random traffic.
  task automatic test_random_phase(input logic [15:0] period_cfg, input int depth,
                                   input int n_items, input bit burst);
    int k;
    begin
      drain_results();
      write_period(period_cfg);
      no_gaps    = burst;
      live_depth = depth;
      for (k = 0; k < depth; k++) send_item(random_load(5'(k), 8'($urandom_range(1, 255))));
      if (depth < TBL) send_item(random_load(5'(depth), 8'd0));
      for (k = 0; k < n_items; k++) begin
        send_item(random_cmd());
        // Let the block empty out now and then before carrying on.
        if (k % 97 == 96) drain_results();
      end
      drain_results();
      no_gaps = 1'b0;
    end
  endtask

  // Test sequence.
  initial begin : run_tests
    int k;
    for (k = 0; k < TBL; k++) begin
      t_code[k]   = '0;
      t_mask[k]   = '0;
      t_next[k]   = '0;
      t_period[k] = '0;
      t_flag[k]   = 1'b0;
      t_pend[k]   = 1'b0;
      t_start[k]  = '0;
    end
    cur_state  = pcs_pkg::STATE_INIT;
    err_flag   = 1'b0;
    err_period = pcs_pkg::ERR_PERIOD_RST;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_load_and_issue();
    test_unknown_state();
    test_random_phase(16'd0, 6, 200, 1'b0);
    test_random_phase(16'hFFFF, 10, 200, 1'b0);
    test_random_phase(16'd3, 32, 120, 1'b1);
    test_random_phase(16'($urandom_range(1, 4)), 4, 250, 1'b0);

    repeat (40) @(posedge clk);
    $display("Run covered %0d loads, %0d posts, %0d runs and %0d responses;",
             kind_count[pcs_pkg::KIND_LOAD], kind_count[pcs_pkg::KIND_POST],
             kind_count[pcs_pkg::KIND_RUN], kind_count[pcs_pkg::KIND_RESP]);
    $display("%0d commands were issued and the error period was rewritten %0d times.",
             sends_seen, cfg_writes);
    if (errors == 0 && report_q.size() == 0) begin
      $display("periodic_command_scheduler verification clean");
    end else begin
      $display("periodic_command_scheduler verification failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5000000;
    $display("periodic_command_scheduler verification failed");
    $finish;
  end

endmodule
